[src/tpi_pkg.sv]
`default_nettype none

package tpi_pkg;

   // Fixed geometry: 8x8 tiles, 64 bytes per tile
   localparam int unsigned TILE_SHIFT = 3;
   localparam int unsigned TILE_BYTES_SHIFT = 6;

   // Configuration register indexes
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_TILE_LIMIT   = 2'd2;

   typedef struct packed {
      logic [9:0]  pix_x;
      logic [9:0]  pix_y;
      logic [31:0] pixel_color;
   } req_word_type;

   typedef struct packed {
      logic [19:0] dest_index;
      logic        in_range;
      logic [7:0]  color_id;
      logic        is_new_color;
      logic [14:0] palette_word;
      logic        palette_full;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_RD,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;   // capture request word
      logic mul;    // register products
      logic sum;    // index, range test, clear search
      logic read;   // read palette at search pointer
      logic step;   // advance search pointer
      logic hit;    // color found at search pointer
      logic miss;   // color absent: append or flag full
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic at_end;
      logic match;
   } sts_type;

   function automatic logic [14:0] pack555(input logic [31:0] argb);
      pack555 = {argb[23:19], argb[15:11], argb[7:3]};
   endfunction

endpackage

`default_nettype wire

[src/tile_palette_indexer_unit.sv]
`default_nettype none

// Channel   Ports                                   Direction  Handshake
// req       start, busy, req_word                   in         start & !busy
// rsp       rsp_valid, rsp_word                     out        one-cycle strobe
// csr       csr_valid, csr_ready, csr_index, data   in         valid & ready
//
// Timing: an out-of-range pixel goes from accept through the MUL, SUM, RD and
// DONE states to the strobe. In range, the palette is scanned entry by entry,
// each in an RD then a CMP state (registered read, then compare), until a hit
// or the last stored color. The single read port of the palette store sets this pace.
// Reset: synchronous; clears the color count, so no clearing pass is needed.
// Stalls: the receiver cannot stall; busy holds off new words through the strobe.

module tile_palette_indexer_unit #(
   parameter int unsigned PALETTE_SIZE = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request
   input  wire logic                  start,
   output logic                       busy,
   input  wire tpi_pkg::req_word_type req_word,
   // result
   output logic                       rsp_valid,
   output tpi_pkg::rsp_word_type      rsp_word,
   // configuration
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [1:0]            csr_index,
   input  wire logic [15:0]           csr_data
);

   tpi_pkg::cmd_type cmd;
   tpi_pkg::sts_type sts;

   // Writes must come only while idle (the block does not enforce it); the port always takes them.
   assign csr_ready = 1'b1;

   tpi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   tpi_datapath #(
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_word  (req_word),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_word  (rsp_word)
   );

   // Result strobe is a single cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // No new word is taken on the strobe cycle.
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while not busy");

   // A color cannot be both added and refused.
   a_new_or_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.is_new_color && rsp_word.palette_full))
      else $error("new color and full flag together");

   // Out-of-range pixels leave the palette untouched.
   a_out_of_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.in_range) |->
         (rsp_word.color_id == 8'd0 && !rsp_word.is_new_color
          && !rsp_word.palette_full))
      else $error("palette fields set for out-of-range pixel");

endmodule

`default_nettype wire

[src/tpi_ctrl.sv]
`default_nettype none

module tpi_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   output logic                  rsp_valid,
   output tpi_pkg::cmd_type      cmd,
   input  wire tpi_pkg::sts_type sts
);

   tpi_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tpi_pkg::ST_IDLE: begin
            if (start) begin
               state_in = tpi_pkg::ST_MUL;
            end
         end
         tpi_pkg::ST_MUL: state_in = tpi_pkg::ST_SUM;
         tpi_pkg::ST_SUM: state_in = tpi_pkg::ST_RD;
         tpi_pkg::ST_RD: begin
            if (!sts.in_range || sts.at_end) begin
               state_in = tpi_pkg::ST_DONE;
            end else begin
               state_in = tpi_pkg::ST_CMP;
            end
         end
         tpi_pkg::ST_CMP: begin
            if (sts.match) begin
               state_in = tpi_pkg::ST_DONE;
            end else begin
               state_in = tpi_pkg::ST_RD;
            end
         end
         tpi_pkg::ST_DONE: state_in = tpi_pkg::ST_IDLE;
         default: state_in = tpi_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         tpi_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         tpi_pkg::ST_MUL: cmd.mul = 1'b1;
         tpi_pkg::ST_SUM: cmd.sum = 1'b1;
         tpi_pkg::ST_RD: begin
            if (sts.in_range) begin
               cmd.miss = sts.at_end;
               cmd.read = !sts.at_end;
            end
         end
         tpi_pkg::ST_CMP: begin
            cmd.hit  = sts.match;
            cmd.step = !sts.match;
         end
         tpi_pkg::ST_DONE: rsp_valid = 1'b1;
         default: busy = 1'b1;
      endcase
   end

endmodule

`default_nettype wire

[src/tpi_datapath.sv]
`default_nettype none

module tpi_datapath #(
   parameter int unsigned PALETTE_SIZE = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [1:0]            csr_index,
   input  wire logic [15:0]           csr_data,
   input  wire tpi_pkg::req_word_type req_word,
   input  wire tpi_pkg::cmd_type      cmd,
   output tpi_pkg::sts_type           sts,
   output tpi_pkg::rsp_word_type      rsp_word
);

   localparam int unsigned AW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
   localparam int unsigned CW = $clog2(PALETTE_SIZE + 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(PALETTE_SIZE);

   // Configuration
   logic [10:0] width_ff, height_ff;
   logic [14:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd8;
         height_ff <= 11'd8;
         limit_ff  <= 15'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            tpi_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_data[10:0];
            tpi_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_data[10:0];
            tpi_pkg::CSR_TILE_LIMIT:   limit_ff  <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // Request word
   logic [9:0]  x_ff, y_ff;
   logic [31:0] color_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff     <= req_word.pix_x;
         y_ff     <= req_word.pix_y;
         color_ff <= req_word.pixel_color;
      end
   end

   // Products: tile-row offset and image area
   logic [14:0] row_prod_ff, row_prod_in;
   logic [21:0] area_ff, area_in;

   assign row_prod_in = {7'd0, width_ff[10:3]} * {8'd0, y_ff[9:3]};
   assign area_in     = {11'd0, width_ff} * {11'd0, height_ff};

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         row_prod_ff <= row_prod_in;
         area_ff     <= area_in;
      end
   end

   // Tile-linear index and range test
   logic [21:0] idx_ff, idx_in;
   logic [15:0] tiles;
   logic        inr_ff, inr_in;

   assign idx_in = {1'b0, row_prod_ff, 6'd0}
                 + {9'd0, x_ff[9:3], 6'd0}
                 + {16'd0, y_ff[2:0], x_ff[2:0]};
   assign tiles  = (limit_ff == 15'd0) ? area_ff[21:6] : {1'b0, limit_ff};
   assign inr_in = idx_in[21:6] < tiles;

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         idx_ff <= idx_in;
      end
   end

   // Palette store and search
   logic [31:0]   palette_ff [PALETTE_SIZE];
   logic [31:0]   rd_data_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] id_ff, id_in;
   logic          new_ff, new_in;
   logic          full_ff, full_in;
   logic          room;

   assign room = count_ff != COUNT_MAX;

   always_ff @(posedge clock) begin
      if (cmd.miss && room) begin
         palette_ff[count_ff[AW-1:0]] <= color_ff;
      end
      if (cmd.read) begin
         rd_data_ff <= palette_ff[ptr_ff[AW-1:0]];
      end
   end

   always_comb begin
      count_in = count_ff;
      ptr_in   = ptr_ff;
      id_in    = id_ff;
      new_in   = new_ff;
      full_in  = full_ff;
      if (cmd.sum) begin
         ptr_in  = '0;
         id_in   = '0;
         new_in  = 1'b0;
         full_in = 1'b0;
      end
      if (cmd.step) begin
         ptr_in = ptr_ff + CW'(1);
      end
      if (cmd.hit) begin
         id_in = ptr_ff[AW-1:0];
      end
      if (cmd.miss) begin
         if (room) begin
            id_in    = count_ff[AW-1:0];
            new_in   = 1'b1;
            count_in = count_ff + CW'(1);
         end else begin
            id_in   = '0;
            full_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      id_ff   <= id_in;
      new_ff  <= new_in;
      full_ff <= full_in;
      if (cmd.sum) begin
         inr_ff <= inr_in;
      end
   end

   assign sts.in_range = inr_ff;
   assign sts.at_end   = ptr_ff == count_ff;
   assign sts.match    = rd_data_ff == color_ff;

   assign rsp_word.dest_index   = idx_ff[19:0];
   assign rsp_word.in_range     = inr_ff;
   assign rsp_word.color_id     = 8'(id_ff);
   assign rsp_word.is_new_color = new_ff;
   assign rsp_word.palette_word = tpi_pkg::pack555(color_ff);
   assign rsp_word.palette_full = full_ff;

endmodule

`default_nettype wire
